// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

`endif

// ===== sv/smtbs_pkg.sv =====
// ----------------------------------------------------------------------------
// smtbs_pkg
// Types and constants for the seeded multi-table byte substitution unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smtbs_pkg;

  localparam int MAX_TABLES_DEF = 8;

  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;

  localparam logic CFG_SEED   = 1'b0;
  localparam logic CFG_TCOUNT = 1'b1;

  typedef enum logic [1:0] {
    OP_BUILD = 2'd0,
    OP_ENC   = 2'd1,
    OP_DEC   = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DATA      = 2'd0,
    ST_BUILT     = 2'd1,
    ST_NOT_BUILT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_CLR,
    BS_LCG,
    BS_PROBE,
    BS_DONE
  } bld_state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       message_start;
  } in_req_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic [1:0] status;
  } out_rsp_t;

  // builder status toward the data path
  typedef struct packed {
    logic busy;
    logic wr_en;
    logic done;
  } bld_stat_t;

endpackage

// ===== sv/seeded_multi_table_byte_substitution_unit.sv =====
// ----------------------------------------------------------------------------
// seeded_multi_table_byte_substitution_unit
// Builds seeded substitution tables in RAM and substitutes bytes through them.
// ----------------------------------------------------------------------------
//  channel  | ports                            | handshake
//  ---------+----------------------------------+------------------------------
//  request  | start, busy, in_req              | taken when start && !busy
//  result   | out_valid, out_rsp               | one-cycle strobe, no stall
//  config   | cfg_we, cfg_index, cfg_wdata     | write when cfg_we
//
//  Encrypt/decrypt: one request per cycle while busy is low, result in the
//  cycle after acceptance (one forward or inverse RAM read).
//  Build: per table, a pass over all 256 entries clears the used marks, then
//  each of 256 entries takes three LCG steps plus one probe per code tried.
//  A closing state follows the last write and the result strobes in the
//  cycle after it; busy is high from the cycle after acceptance to that state.
//  No clearing pass after reset. The result side has no backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module seeded_multi_table_byte_substitution_unit #(
  parameter int MAX_TABLES = smtbs_pkg::MAX_TABLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  smtbs_pkg::in_req_t in_req,
  output logic               out_valid,
  output smtbs_pkg::out_rsp_t out_rsp,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int TW    = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int DEPTH = MAX_TABLES * 256;
  localparam int AW    = $clog2(DEPTH);

  logic [31:0]   seed_r;
  logic [3:0]    tcount_r;
  logic          ready_r;
  logic [TW-1:0] pos_r, pos_nxt;
  logic [TW-1:0] blast_r;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_stat_r, out_stat_nxt;
  logic          out_data_r, out_data_nxt;
  logic          out_inv_r, out_inv_nxt;

  smtbs_pkg::bld_stat_t bstat;
  logic [TW-1:0] b_tbl;
  logic [7:0]    b_idx;
  logic [7:0]    b_code;
  logic [TW-1:0] b_last;

  logic          accept;
  logic          is_build;
  logic          is_xlat;
  logic          rd_en;
  logic [TW-1:0] p0;
  logic [AW-1:0] rd_addr;
  logic [7:0]    fwd_rdata;
  logic [7:0]    inv_rdata;

  assign accept   = start && !busy;
  assign is_build = (in_req.opcode == smtbs_pkg::OP_BUILD);
  assign is_xlat  = (in_req.opcode == smtbs_pkg::OP_ENC) ||
                    (in_req.opcode == smtbs_pkg::OP_DEC);
  assign rd_en    = accept && is_xlat && ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= 32'd0;
      tcount_r <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        smtbs_pkg::CFG_SEED:   seed_r   <= cfg_wdata;
        smtbs_pkg::CFG_TCOUNT: tcount_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  smtbs_builder #(
    .MAX_TABLES (MAX_TABLES)
  ) u_builder (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (accept && is_build),
    .seed        (seed_r),
    .table_count (tcount_r),
    .stat        (bstat),
    .tbl         (b_tbl),
    .idx         (b_idx),
    .code        (b_code),
    .last_tbl    (b_last)
  );

  assign busy = bstat.busy;

  // table position for this byte and the one after it
  always_comb begin
    p0 = in_req.message_start ? '0 : pos_r;
    if (p0 > blast_r) p0 = '0;
    pos_nxt = (p0 == blast_r) ? '0 : p0 + TW'(1);
    rd_addr = AW'({p0, in_req.data_byte});
  end

  smtbs_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_fwd_ram (
    .clk   (clk),
    .we    (bstat.wr_en),
    .waddr (AW'({b_tbl, b_idx})),
    .wdata (b_code),
    .re    (rd_en && (in_req.opcode == smtbs_pkg::OP_ENC)),
    .raddr (rd_addr),
    .rdata (fwd_rdata)
  );

  smtbs_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_inv_ram (
    .clk   (clk),
    .we    (bstat.wr_en),
    .waddr (AW'({b_tbl, b_code})),
    .wdata (b_idx),
    .re    (rd_en && (in_req.opcode == smtbs_pkg::OP_DEC)),
    .raddr (rd_addr),
    .rdata (inv_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
      pos_r   <= '0;
      blast_r <= '0;
    end else if (bstat.done) begin
      ready_r <= 1'b1;
      pos_r   <= '0;
      blast_r <= b_last;
    end else if (rd_en) begin
      pos_r <= pos_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = 1'b0;
    out_stat_nxt  = smtbs_pkg::ST_DATA;
    out_data_nxt  = 1'b0;
    out_inv_nxt   = 1'b0;
    if (bstat.done) begin
      out_valid_nxt = 1'b1;
      out_stat_nxt  = smtbs_pkg::ST_BUILT;
    end else if (accept && !is_build) begin
      out_valid_nxt = 1'b1;
      if (is_xlat && !ready_r) begin
        out_stat_nxt = smtbs_pkg::ST_NOT_BUILT;
      end else if (is_xlat) begin
        out_data_nxt = 1'b1;
        out_inv_nxt  = (in_req.opcode == smtbs_pkg::OP_DEC);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_stat_r <= out_stat_nxt;
    out_data_r <= out_data_nxt;
    out_inv_r  <= out_inv_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_rsp.status      = out_stat_r;
  assign out_rsp.result_byte = !out_data_r ? 8'h00 : (out_inv_r ? inv_rdata : fwd_rdata);

endmodule

// ===== sv/smtbs_ram.sv =====
// ----------------------------------------------------------------------------
// smtbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smtbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/smtbs_builder.sv =====
// ----------------------------------------------------------------------------
// smtbs_builder
// Table build sequencer: per-table clear of the used-mark RAM, LCG key
// stepping, linear probing over the marks, and write requests for the
// forward and inverse tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smtbs_builder #(
  parameter int MAX_TABLES = smtbs_pkg::MAX_TABLES_DEF,
  localparam int TW = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [31:0]          seed,
  input  logic [3:0]           table_count,
  output smtbs_pkg::bld_stat_t stat,
  output logic [TW-1:0]        tbl,
  output logic [7:0]           idx,
  output logic [7:0]           code,
  output logic [TW-1:0]        last_tbl
);

  smtbs_pkg::bld_state_t state_r, state_nxt;

  logic [31:0]   key_r;
  logic [31:0]   key_lcg;
  logic [1:0]    step_r;
  logic [TW-1:0] tbl_r;
  logic [7:0]    idx_r;
  logic [7:0]    code_r;
  logic [TW-1:0] last_r;
  logic [TW-1:0] last_nxt;
  logic          hit;
  logic          mark_we;
  logic [7:0]    mark_waddr;
  logic          mark_wdata;
  logic          mark_re;
  logic [7:0]    mark_raddr;
  logic          mark_rdata;

  assign key_lcg = key_r * smtbs_pkg::LCG_MUL + smtbs_pkg::LCG_ADD;
  assign hit     = mark_rdata;

  // clear pass writes zeros by entry index; a probe that lands marks its code
  assign mark_we    = (state_r == smtbs_pkg::BS_CLR) ||
                      ((state_r == smtbs_pkg::BS_PROBE) && !hit);
  assign mark_waddr = (state_r == smtbs_pkg::BS_CLR) ? idx_r : code_r;
  assign mark_wdata = (state_r == smtbs_pkg::BS_PROBE);
  // first mark read issues with the third LCG step, later ones walk upward
  assign mark_re    = (state_r == smtbs_pkg::BS_PROBE) ||
                      ((state_r == smtbs_pkg::BS_LCG) && (step_r == 2'd2));
  assign mark_raddr = (state_r == smtbs_pkg::BS_PROBE) ? code_r + 8'd1 : key_lcg[7:0];

  smtbs_ram #(
    .WIDTH (1),
    .DEPTH (256)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .re    (mark_re),
    .raddr (mark_raddr),
    .rdata (mark_rdata)
  );

  // clamp table_count into 1..MAX_TABLES
  always_comb begin
    int n;
    n = int'(table_count);
    if (n < 1) n = 1;
    if (n > MAX_TABLES) n = MAX_TABLES;
    last_nxt = TW'(n - 1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      smtbs_pkg::BS_IDLE: begin
        if (go) state_nxt = smtbs_pkg::BS_CLR;
      end
      smtbs_pkg::BS_CLR: begin
        if (idx_r == 8'hFF) state_nxt = smtbs_pkg::BS_LCG;
      end
      smtbs_pkg::BS_LCG: begin
        if (step_r == 2'd2) state_nxt = smtbs_pkg::BS_PROBE;
      end
      smtbs_pkg::BS_PROBE: begin
        if (!hit) begin
          if (idx_r == 8'hFF && tbl_r == last_r) state_nxt = smtbs_pkg::BS_DONE;
          else if (idx_r == 8'hFF) state_nxt = smtbs_pkg::BS_CLR;
          else state_nxt = smtbs_pkg::BS_LCG;
        end
      end
      smtbs_pkg::BS_DONE: begin
        state_nxt = smtbs_pkg::BS_IDLE;
      end
      default: state_nxt = smtbs_pkg::BS_IDLE;
    endcase
  end

  always_comb begin
    stat.busy  = (state_r != smtbs_pkg::BS_IDLE);
    stat.wr_en = (state_r == smtbs_pkg::BS_PROBE) && !hit;
    stat.done  = (state_r == smtbs_pkg::BS_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smtbs_pkg::BS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      smtbs_pkg::BS_IDLE: begin
        if (go) begin
          key_r  <= seed;
          step_r <= 2'd0;
          tbl_r  <= '0;
          idx_r  <= 8'd0;
          last_r <= last_nxt;
        end
      end
      smtbs_pkg::BS_CLR: begin
        // wraps back to entry 0 for the fill
        idx_r <= idx_r + 8'd1;
      end
      smtbs_pkg::BS_LCG: begin
        key_r  <= key_lcg;
        step_r <= step_r + 2'd1;
        if (step_r == 2'd2) code_r <= key_lcg[7:0];
      end
      smtbs_pkg::BS_PROBE: begin
        if (hit) begin
          code_r <= code_r + 8'd1;
        end else begin
          step_r <= 2'd0;
          idx_r  <= idx_r + 8'd1;
          if (idx_r == 8'hFF) begin
            tbl_r <= tbl_r + TW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign tbl      = tbl_r;
  assign idx      = idx_r;
  assign code     = code_r;
  assign last_tbl = last_r;

endmodule

// ===== sv/smtbs_chk.sv =====
// ----------------------------------------------------------------------------
// smtbs_chk
// Port-level checks for the substitution unit, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smtbs_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input smtbs_pkg::in_req_t  in_req,
  input logic                out_valid,
  input smtbs_pkg::out_rsp_t out_rsp
);

  logic acc_build;
  logic acc_other;

  assign acc_build = start && !busy && (in_req.opcode == smtbs_pkg::OP_BUILD);
  assign acc_other = start && !busy && (in_req.opcode != smtbs_pkg::OP_BUILD);

  // every non-build request answers in the next cycle
  `CHK_NEXT(a_xlat_lat, clk, rst_n, acc_other, out_valid)

  // a build request occupies the unit
  `CHK_NEXT(a_build_busy, clk, rst_n, acc_build, busy && !out_valid)

  // build completion only comes out of a busy period
  `CHK_SAME(a_built_after_busy, clk, rst_n,
            out_valid && (out_rsp.status == smtbs_pkg::ST_BUILT), $past(busy) && !busy)

  // non-data statuses carry a zero byte
  `CHK_SAME(a_zero_byte, clk, rst_n,
            out_valid && (out_rsp.status != smtbs_pkg::ST_DATA), out_rsp.result_byte == 8'h00)

endmodule

bind seeded_multi_table_byte_substitution_unit smtbs_chk u_smtbs_chk (.*);

// ===== tb/tb_seeded_multi_table_byte_substitution_unit.sv =====
// ----------------------------------------------------------------------------
// tb_seeded_multi_table_byte_substitution_unit
// Drives build, encrypt, decrypt and no-op requests into the substitution
// unit under changing seed and table-count settings. A scoreboard rebuilds
// the seeded tables on its own, predicts each result and checks every result
// strobe against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_seeded_multi_table_byte_substitution_unit;
  import smtbs_pkg::*;

  localparam int NUM_TABLES     = MAX_TABLES_DEF;
  localparam int RANDOM_ITEMS   = 600;
  // worst build: every table, every entry probing all 256 codes, then margin
  localparam int WATCHDOG_LIMIT = 2_000_000;

  class substitution_tracker;
    bit [7:0]    fwd_map [NUM_TABLES][256];
    bit [7:0]    inv_map [NUM_TABLES][256];
    bit [31:0]   key;
    bit [31:0]   seed_reg;
    bit [3:0]    count_reg;
    int unsigned built_tables;
    int unsigned position;
    bit          ready;
    out_rsp_t    pending_results[$];
    int          errors;

    function new();
      key          = '0;
      seed_reg     = '0;
      count_reg    = 4'd1;
      built_tables = 1;
      position     = 0;
      ready        = 1'b0;
      errors       = 0;
    endfunction

    function void write_register(logic idx, bit [31:0] value);
      if (idx == CFG_SEED) seed_reg = value;
      else count_reg = value[3:0];
    endfunction

    function void build_tables();
      int unsigned n;
      bit [255:0]  taken;
      bit [7:0]    code;
      n = count_reg;
      if (n < 1) n = 1;
      if (n > NUM_TABLES) n = NUM_TABLES;
      key = seed_reg;
      for (int t = 0; t < n; t++) begin
        taken = '0;
        for (int i = 0; i < 256; i++) begin
          repeat (3) key = key * LCG_MUL + LCG_ADD;
          code = key[7:0];
          while (taken[code]) code = code + 8'd1;
          taken[code]     = 1'b1;
          fwd_map[t][i]    = code;
          inv_map[t][code] = i[7:0];
        end
      end
      built_tables = n;
      position     = 0;
      ready        = 1'b1;
    endfunction

    function void note_request(in_req_t r);
      out_rsp_t    want;
      int unsigned p;
      want.result_byte = 8'h00;
      want.status      = ST_DATA;
      case (opcode_t'(r.opcode))
        OP_BUILD: begin
          build_tables();
          want.status = ST_BUILT;
        end
        OP_ENC, OP_DEC: begin
          if (!ready) begin
            want.status = ST_NOT_BUILT;
          end else begin
            if (r.message_start) position = 0;
            p = (position >= built_tables) ? 0 : position;
            want.result_byte = (r.opcode == OP_ENC) ? fwd_map[p][r.data_byte]
                                                    : inv_map[p][r.data_byte];
            p++;
            position = (p >= built_tables) ? 0 : p;
          end
        end
        default: ;
      endcase
      pending_results.push_back(want);
    endfunction

    function void check_result(out_rsp_t got);
      out_rsp_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none pending: expected none, actual byte %02h status %0d",
                 $time, got.result_byte, got.status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.result_byte !== want.result_byte) begin
        $display("%0t: result_byte expected %02h actual %02h",
                 $time, want.result_byte, got.result_byte);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_req_t     in_req;
  logic        out_valid;
  out_rsp_t    out_rsp;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  substitution_tracker board;
  bit                  no_idle;
  int                  data_sent;
  int                  quiet_cycles;

  seeded_multi_table_byte_substitution_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // result checked before the new request is noted: it belongs to an older one
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) board.check_result(out_rsp);
      if (start && !busy) board.note_request(in_req);
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("seeded_multi_table_byte_substitution_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_req_t make_req(opcode_t op, bit [7:0] data, bit first);
    in_req_t r;
    r.opcode        = op;
    r.data_byte     = data;
    r.message_start = first;
    return r;
  endfunction

  // entered at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(in_req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    if (r.opcode != OP_NOP) data_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (board.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(logic idx, bit [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    board.write_register(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic bit [31:0] pick_table_count();
    int          sel;
    bit [31:0]   value;
    sel = $urandom_range(0, 9);
    if (sel <= 5) value = $urandom_range(1, 3);
    else if (sel <= 7) value = $urandom_range(4, 8);
    else if (sel == 8) value = $urandom_range(0, 1) ? 0 : 8;
    else value = $urandom_range(9, 15);
    // upper bits lie outside the register and must be dropped
    if ($urandom_range(0, 3) == 0) value[31:4] = 28'($urandom);
    return value;
  endfunction

  task automatic send_message();
    int      len;
    int      pick;
    opcode_t op;
    len = $urandom_range(1, 24);
    for (int i = 0; i < len; i++) begin
      op   = $urandom_range(0, 1) ? OP_ENC : OP_DEC;
      pick = $urandom_range(0, 39);
      if (pick == 0) send_request(make_req(OP_BUILD, 8'($urandom), 1'($urandom)));
      else if (pick <= 2) send_request(make_req(OP_NOP, 8'($urandom), 1'($urandom)));
      else if (pick <= 4) send_request(make_req(op, 8'($urandom), 1'($urandom)));
      else send_request(make_req(op, 8'($urandom), i == 0));
    end
  endtask

  initial begin
    board     = new();
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_index = 1'b0;
    cfg_wdata = '0;
    no_idle   = 1'b0;
    data_sent = 0;
    quiet_cycles = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // data before any build, and a no-op
    send_request(make_req(OP_ENC, 8'h00, 1'b1));
    send_request(make_req(OP_DEC, 8'hFF, 1'b0));
    send_request(make_req(OP_NOP, 8'hA5, 1'b1));
    wait_idle();

    // zero count builds one table
    write_register(CFG_SEED, 32'h0000_0000);
    write_register(CFG_TCOUNT, 32'd0);
    send_request(make_req(OP_BUILD, 8'hFF, 1'b0));
    send_request(make_req(OP_ENC, 8'h00, 1'b1));
    send_request(make_req(OP_ENC, 8'hFF, 1'b0));
    send_request(make_req(OP_DEC, 8'h00, 1'b0));
    send_request(make_req(OP_DEC, 8'hFF, 1'b1));
    send_request(make_req(OP_NOP, 8'h3C, 1'b0));
    send_request(make_req(OP_ENC, 8'h5A, 1'b0));
    wait_idle();

    // count above the maximum clamps; walk past the last table
    write_register(CFG_SEED, 32'hFFFF_FFFF);
    write_register(CFG_TCOUNT, 32'd15);
    send_request(make_req(OP_BUILD, 8'h00, 1'b1));
    for (int i = 0; i < 9; i++)
      send_request(make_req(OP_ENC, 8'(i * 29), i == 0));
    send_request(make_req(OP_DEC, 8'h81, 1'b1));
    wait_idle();

    // count changed without a rebuild keeps the built set
    write_register(CFG_TCOUNT, 32'd3);
    send_request(make_req(OP_ENC, 8'h11, 1'b0));
    send_request(make_req(OP_DEC, 8'h22, 1'b0));
    send_request(make_req(OP_ENC, 8'h33, 1'b0));
    send_request(make_req(OP_BUILD, 8'h44, 1'b0));
    send_request(make_req(OP_ENC, 8'h55, 1'b0));

    data_sent = 0;
    while (data_sent < RANDOM_ITEMS) begin
      wait_idle();
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) write_register(CFG_SEED, $urandom);
      if ($urandom_range(0, 3) != 0) write_register(CFG_TCOUNT, pick_table_count());
      if ($urandom_range(0, 4) != 0)
        send_request(make_req(OP_BUILD, 8'($urandom), 1'($urandom)));
      repeat ($urandom_range(1, 4)) send_message();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("seeded_multi_table_byte_substitution_unit: match");
    end else begin
      $display("seeded_multi_table_byte_substitution_unit: mismatch");
    end
    $finish;
  end

endmodule
